@@ hdl/assert_macros.svh @@
// assertion helpers, clk and rst_n must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/scm_pkg.sv @@
`default_nettype none
package scm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int RECORD_LEN  = 240;
  localparam int IDX_BITS    = 8;
  localparam int MV_BITS     = 12;
  localparam int ROW_BITS    = 8;
  localparam int DEC_BITS    = 7;
  localparam int CFG_BITS    = 12;

  localparam int MV_FULL  = 3600;
  localparam int ROW_FULL = 240;
  localparam int MV_CONST_BITS  = 12;
  localparam int ROW_CONST_BITS = 8;
  localparam int TRIG_LEVEL_RST = 2048;

  localparam int MV_SUM_BITS  = $clog2(RECORD_LEN * MV_FULL);
  localparam int ROW_SUM_BITS = $clog2(RECORD_LEN * ROW_FULL);

  // floor(sum / RECORD_LEN) as multiply by rounded-up reciprocal, exact for sum < 2^MV_SUM_BITS
  localparam int AVG_SHIFT      = MV_SUM_BITS + $clog2(RECORD_LEN);
  localparam int AVG_RECIP_BITS = AVG_SHIFT - $clog2(RECORD_LEN) + 1;
  localparam longint unsigned AVG_RECIP =
    ((longint'(1) << AVG_SHIFT) + RECORD_LEN - 1) / RECORD_LEN;

  typedef enum logic [1:0] {
    CFG_TIMEBASE,
    CFG_TRIG_EN,
    CFG_TRIG_LEVEL,
    CFG_HOLD
  } cfg_idx_t;

  localparam logic [1:0] TB_EVERY     = 2'd0;
  localparam logic [1:0] TB_TENTH     = 2'd1;
  localparam logic [1:0] TB_HUNDREDTH = 2'd2;

  typedef struct packed {
    logic [1:0]             timebase;
    logic                   trig_en;
    logic [SAMPLE_BITS-1:0] trig_level;
    logic                   hold;
  } cfg_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]     idx;
    logic [MV_BITS-1:0]      mv;
    logic [ROW_BITS-1:0]     row;
    logic                    done;
    logic [MV_BITS-1:0]      vmin;
    logic [MV_BITS-1:0]      vmax;
    logic [MV_SUM_BITS-1:0]  mv_sum;
    logic [ROW_SUM_BITS-1:0] row_sum;
  } meas_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] sample_index;
    logic [MV_BITS-1:0]  millivolts;
    logic [ROW_BITS-1:0] screen_row;
    logic                record_done;
    logic [MV_BITS-1:0]  volt_min;
    logic [MV_BITS-1:0]  volt_max;
    logic [MV_BITS-1:0]  volt_avg;
    logic [MV_BITS-1:0]  volt_peak_to_peak;
    logic [ROW_BITS-1:0] row_avg;
  } res_t;

  function automatic logic [DEC_BITS-1:0] ratio_of_mode(input logic [1:0] mode);
    logic [DEC_BITS-1:0] r;
    case (mode)
      TB_TENTH:     r = DEC_BITS'(10);
      TB_HUNDREDTH: r = DEC_BITS'(100);
      default:      r = DEC_BITS'(1);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/scm_in_if.sv @@
`default_nettype none
interface scm_in_if;
  logic                            valid;
  logic                            ready;
  logic [scm_pkg::SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

@@ hdl/scm_out_if.sv @@
`default_nettype none
interface scm_out_if;
  logic                         valid;
  logic                         ready;
  logic [scm_pkg::IDX_BITS-1:0] sample_index;
  logic [scm_pkg::MV_BITS-1:0]  millivolts;
  logic [scm_pkg::ROW_BITS-1:0] screen_row;
  logic                         record_done;
  logic [scm_pkg::MV_BITS-1:0]  volt_min;
  logic [scm_pkg::MV_BITS-1:0]  volt_max;
  logic [scm_pkg::MV_BITS-1:0]  volt_avg;
  logic [scm_pkg::MV_BITS-1:0]  volt_peak_to_peak;
  logic [scm_pkg::ROW_BITS-1:0] row_avg;

  modport source (output valid, output sample_index, output millivolts, output screen_row,
                  output record_done, output volt_min, output volt_max, output volt_avg,
                  output volt_peak_to_peak, output row_avg, input ready);
  modport sink   (input valid, input sample_index, input millivolts, input screen_row,
                  input record_done, input volt_min, input volt_max, input volt_avg,
                  input volt_peak_to_peak, input row_avg, output ready);
endinterface
`default_nettype wire

@@ hdl/scm_config.sv @@
`default_nettype none
module scm_config (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  scm_pkg::cfg_idx_t             cfg_idx,
  input  logic [scm_pkg::CFG_BITS-1:0]  cfg_wdata,
  output scm_pkg::cfg_t                 cfg
);
  import scm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timebase   <= TB_EVERY;
      cfg_r.trig_en    <= 1'b0;
      cfg_r.trig_level <= SAMPLE_BITS'(TRIG_LEVEL_RST);
      cfg_r.hold       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TIMEBASE:   cfg_r.timebase   <= cfg_wdata[1:0];
        CFG_TRIG_EN:    cfg_r.trig_en    <= cfg_wdata[0];
        CFG_TRIG_LEVEL: cfg_r.trig_level <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_HOLD:       cfg_r.hold       <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hdl/scm_acquire.sv @@
`default_nettype none
module scm_acquire (
  input  logic           clk,
  input  logic           rst_n,
  input  scm_pkg::cfg_t  cfg,
  scm_in_if.sink         in_ch,
  output scm_pkg::meas_t meas,
  output logic           meas_valid,
  input  logic           meas_ready
);
  import scm_pkg::*;

  localparam int MV_PROD_BITS  = SAMPLE_BITS + MV_CONST_BITS;
  localparam int ROW_PROD_BITS = SAMPLE_BITS + ROW_CONST_BITS;

  logic                    a_valid_r;
  logic [SAMPLE_BITS-1:0]  a_x_r;
  logic                    b_valid_r;
  meas_t                   b_data_r;

  logic                    capturing_r, capturing_nxt;
  logic [DEC_BITS-1:0]     dec_cnt_r, dec_cnt_nxt;
  logic [IDX_BITS-1:0]     wr_idx_r, wr_idx_nxt;
  logic [MV_BITS-1:0]      run_min_r, run_min_nxt;
  logic [MV_BITS-1:0]      run_max_r, run_max_nxt;
  logic [MV_SUM_BITS-1:0]  mv_sum_r, mv_sum_nxt;
  logic [ROW_SUM_BITS-1:0] row_sum_r, row_sum_nxt;

  logic                    advance;
  logic                    start;
  logic                    keep;
  logic                    last;
  logic [DEC_BITS-1:0]     cnt_cur;
  logic [DEC_BITS:0]       cnt_inc;
  logic                    cnt_wrap;
  logic [MV_PROD_BITS-1:0] mv_prod;
  logic [ROW_PROD_BITS-1:0] row_prod;
  logic [MV_BITS-1:0]      mv;
  logic [ROW_BITS-1:0]     row;
  logic [MV_BITS-1:0]      min_new;
  logic [MV_BITS-1:0]      max_new;
  logic [MV_SUM_BITS-1:0]  mv_sum_new;
  logic [ROW_SUM_BITS-1:0] row_sum_new;
  meas_t                   b_data_nxt;

  assign advance     = a_valid_r && (!b_valid_r || meas_ready);
  assign in_ch.ready = !a_valid_r || advance;

  assign start    = !cfg.hold && (capturing_r || !cfg.trig_en || a_x_r == cfg.trig_level);
  assign cnt_cur  = capturing_r ? dec_cnt_r : '0;
  assign keep     = start && (cnt_cur == '0);
  assign cnt_inc  = {1'b0, cnt_cur} + (DEC_BITS+1)'(1);
  assign cnt_wrap = cnt_inc >= {1'b0, ratio_of_mode(cfg.timebase)};

  assign mv_prod  = MV_PROD_BITS'(a_x_r) * MV_PROD_BITS'(MV_FULL);
  assign row_prod = ROW_PROD_BITS'(a_x_r) * ROW_PROD_BITS'(ROW_FULL);
  assign mv       = mv_prod[SAMPLE_BITS +: MV_BITS];
  assign row      = row_prod[SAMPLE_BITS +: ROW_BITS];

  assign min_new     = (mv < run_min_r) ? mv : run_min_r;
  assign max_new     = (mv > run_max_r) ? mv : run_max_r;
  assign mv_sum_new  = mv_sum_r + MV_SUM_BITS'(mv);
  assign row_sum_new = row_sum_r + ROW_SUM_BITS'(row);
  assign last        = wr_idx_r == IDX_BITS'(RECORD_LEN - 1);

  always_comb begin
    b_data_nxt.idx     = wr_idx_r;
    b_data_nxt.mv      = mv;
    b_data_nxt.row     = row;
    b_data_nxt.done    = last;
    b_data_nxt.vmin    = min_new;
    b_data_nxt.vmax    = max_new;
    b_data_nxt.mv_sum  = mv_sum_new;
    b_data_nxt.row_sum = row_sum_new;
  end

  always_comb begin
    capturing_nxt = capturing_r;
    dec_cnt_nxt   = dec_cnt_r;
    wr_idx_nxt    = wr_idx_r;
    run_min_nxt   = run_min_r;
    run_max_nxt   = run_max_r;
    mv_sum_nxt    = mv_sum_r;
    row_sum_nxt   = row_sum_r;
    if (advance && start) begin
      capturing_nxt = 1'b1;
      dec_cnt_nxt   = cnt_wrap ? '0 : cnt_inc[DEC_BITS-1:0];
      if (keep) begin
        if (last) begin
          // record complete, re-arm
          capturing_nxt = 1'b0;
          dec_cnt_nxt   = '0;
          wr_idx_nxt    = '0;
          run_min_nxt   = MV_BITS'(MV_FULL);
          run_max_nxt   = '0;
          mv_sum_nxt    = '0;
          row_sum_nxt   = '0;
        end else begin
          wr_idx_nxt  = wr_idx_r + IDX_BITS'(1);
          run_min_nxt = min_new;
          run_max_nxt = max_new;
          mv_sum_nxt  = mv_sum_new;
          row_sum_nxt = row_sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      capturing_r <= 1'b0;
      dec_cnt_r   <= '0;
      wr_idx_r    <= '0;
      run_min_r   <= MV_BITS'(MV_FULL);
      run_max_r   <= '0;
      mv_sum_r    <= '0;
      row_sum_r   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        a_valid_r <= 1'b1;
      end else if (advance) begin
        a_valid_r <= 1'b0;
      end
      if (advance) begin
        b_valid_r <= keep;
      end else if (meas_ready) begin
        b_valid_r <= 1'b0;
      end
      capturing_r <= capturing_nxt;
      dec_cnt_r   <= dec_cnt_nxt;
      wr_idx_r    <= wr_idx_nxt;
      run_min_r   <= run_min_nxt;
      run_max_r   <= run_max_nxt;
      mv_sum_r    <= mv_sum_nxt;
      row_sum_r   <= row_sum_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_x_r <= in_ch.adc_sample;
    end
    if (advance) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign meas       = b_data_r;
  assign meas_valid = b_valid_r;

endmodule
`default_nettype wire

@@ hdl/scm_measure.sv @@
`default_nettype none
module scm_measure (
  input  logic           clk,
  input  logic           rst_n,
  input  scm_pkg::meas_t meas,
  input  logic           meas_valid,
  output logic           meas_ready,
  scm_out_if.source      out_ch
);
  import scm_pkg::*;

  localparam int MV_AVG_BITS  = MV_SUM_BITS + AVG_RECIP_BITS;
  localparam int ROW_AVG_BITS = ROW_SUM_BITS + AVG_RECIP_BITS;

  logic                     c_valid_r;
  res_t                     c_data_r;
  res_t                     c_data_nxt;
  logic                     load;
  logic [MV_AVG_BITS-1:0]   mv_avg_prod;
  logic [ROW_AVG_BITS-1:0]  row_avg_prod;

  assign meas_ready = !c_valid_r || out_ch.ready;
  assign load       = meas_valid && meas_ready;

  assign mv_avg_prod  = MV_AVG_BITS'(meas.mv_sum) * MV_AVG_BITS'(AVG_RECIP);
  assign row_avg_prod = ROW_AVG_BITS'(meas.row_sum) * ROW_AVG_BITS'(AVG_RECIP);

  always_comb begin
    c_data_nxt.sample_index      = meas.idx;
    c_data_nxt.millivolts        = meas.mv;
    c_data_nxt.screen_row        = meas.row;
    c_data_nxt.record_done       = meas.done;
    c_data_nxt.volt_min          = '0;
    c_data_nxt.volt_max          = '0;
    c_data_nxt.volt_avg          = '0;
    c_data_nxt.volt_peak_to_peak = '0;
    c_data_nxt.row_avg           = '0;
    if (meas.done) begin
      c_data_nxt.volt_min          = meas.vmin;
      c_data_nxt.volt_max          = meas.vmax;
      c_data_nxt.volt_avg          = mv_avg_prod[AVG_SHIFT +: MV_BITS];
      c_data_nxt.volt_peak_to_peak = meas.vmax - meas.vmin;
      c_data_nxt.row_avg           = row_avg_prod[AVG_SHIFT +: ROW_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (load) begin
      c_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign out_ch.valid             = c_valid_r;
  assign out_ch.sample_index      = c_data_r.sample_index;
  assign out_ch.millivolts        = c_data_r.millivolts;
  assign out_ch.screen_row        = c_data_r.screen_row;
  assign out_ch.record_done       = c_data_r.record_done;
  assign out_ch.volt_min          = c_data_r.volt_min;
  assign out_ch.volt_max          = c_data_r.volt_max;
  assign out_ch.volt_avg          = c_data_r.volt_avg;
  assign out_ch.volt_peak_to_peak = c_data_r.volt_peak_to_peak;
  assign out_ch.row_avg           = c_data_r.row_avg;

endmodule
`default_nettype wire

@@ hdl/scope_capture_measure.sv @@
// Scope acquisition with record measurements. Raw 12-bit converter samples enter on in_ch
// one per cycle while in_ch.ready is high; with triggering on, a record starts at the first
// sample equal to the trigger level, otherwise at any sample. Every 1st, 10th or 100th sample
// is kept until 240 are kept; each kept sample gives one transaction on out_ch with its
// millivolt and screen-row values, and the last one of a record also carries min, max, mean
// and peak-to-peak. Skipped or held samples give no transaction. While out_ch is ready the
// block sustains one sample per cycle through an input register, a scaling and accumulation
// stage and an output register. Configuration is written through cfg_we/cfg_idx/cfg_wdata,
// by the user only while no transaction is in flight; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module scope_capture_measure (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  scm_pkg::cfg_idx_t             cfg_idx,
  input  logic [scm_pkg::CFG_BITS-1:0]  cfg_wdata,
  scm_in_if.sink                        in_ch,
  scm_out_if.source                     out_ch
);
  import scm_pkg::*;

  cfg_t  cfg;
  meas_t meas;
  logic  meas_valid;
  logic  meas_ready;

  scm_config u_config (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scm_acquire u_acquire (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .meas       (meas),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready)
  );

  scm_measure u_measure (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas       (meas),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .out_ch     (out_ch)
  );

  `SCM_ASSERT_NOW(a_done_last_idx, out_ch.valid && out_ch.record_done,
    out_ch.sample_index == IDX_BITS'(RECORD_LEN - 1), "record done away from last index")
  `SCM_ASSERT_NOW(a_done_p2p, out_ch.valid && out_ch.record_done,
    out_ch.volt_min <= out_ch.volt_max &&
    out_ch.volt_peak_to_peak == out_ch.volt_max - out_ch.volt_min, "bad peak-to-peak")
  `SCM_ASSERT_NOW(a_mid_zero, out_ch.valid && !out_ch.record_done,
    out_ch.volt_min == '0 && out_ch.volt_avg == '0 && out_ch.row_avg == '0,
    "measurements set mid-record")
  `SCM_ASSERT_NEXT(a_hold_no_kept, cfg.hold && $past(cfg.hold) && !meas_valid,
    !meas_valid, "kept sample while held")

endmodule
`default_nettype wire

@@ tb/sv/scope_capture_measure_test.sv @@
`timescale 1ns / 1ps
module scope_capture_measure_test;
  import scm_pkg::*;

  localparam logic [1:0] TB_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_TIMEBASE;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  logic in_valid_r = 1'b0;
  logic [SAMPLE_BITS-1:0] in_sample_r = '0;
  logic out_ready_r = 1'b0;

  scm_in_if in_bus ();
  scm_out_if out_bus ();

  assign in_bus.valid = in_valid_r;
  assign in_bus.adc_sample = in_sample_r;
  assign out_bus.ready = out_ready_r;

  scope_capture_measure dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  always #5 clk = ~clk;

  // shadow configuration
  logic [1:0] tb_mode = TB_EVERY;
  logic trig_on = 1'b0;
  logic [11:0] trig_lvl = 12'd2048;
  logic hold_on = 1'b0;

  // shadow acquisition state
  logic capturing = 1'b0;
  logic [6:0] dec_count = '0;
  logic [7:0] wr_idx = '0;
  logic [11:0] run_min = 12'd3600;
  logic [11:0] run_max = '0;
  logic [19:0] mv_sum = '0;
  logic [15:0] row_sum = '0;

  res_t kept_sample_q[$];
  logic [SAMPLE_BITS-1:0] adc_pending_q[$];
  res_t pred_res;
  res_t got_res;
  res_t want_res;

  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned results_seen = 0;
  int unsigned random_items = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit steady = 1'b0;

  function automatic bit predict_kept_sample(input logic [11:0] x, output res_t r);
    logic [6:0] ratio;
    logic [11:0] mv;
    logic [7:0] row;
    bit keep;
    r = '0;
    if (hold_on) return 1'b0;
    if (!capturing) begin
      if (trig_on && x != trig_lvl) return 1'b0;
      capturing = 1'b1;
      dec_count = '0;
    end
    case (tb_mode)
      TB_TENTH: ratio = 7'd10;
      TB_HUNDREDTH: ratio = 7'd100;
      default: ratio = 7'd1;
    endcase
    keep = (dec_count == 7'd0);
    dec_count = (32'(dec_count) + 1 >= 32'(ratio)) ? 7'd0 : dec_count + 7'd1;
    if (!keep) return 1'b0;
    mv = 12'((32'(x) * 3600) >> 12);
    row = 8'((32'(x) * 240) >> 12);
    if (mv < run_min) run_min = mv;
    if (mv > run_max) run_max = mv;
    mv_sum = mv_sum + 20'(mv);
    row_sum = row_sum + 16'(row);
    r.sample_index = wr_idx;
    r.millivolts = mv;
    r.screen_row = row;
    if (32'(wr_idx) + 1 >= RECORD_LEN) begin
      r.record_done = 1'b1;
      r.volt_min = run_min;
      r.volt_max = run_max;
      r.volt_avg = 12'(32'(mv_sum) / RECORD_LEN);
      r.volt_peak_to_peak = run_max - run_min;
      r.row_avg = 8'(32'(row_sum) / RECORD_LEN);
      // re-arm
      capturing = 1'b0;
      dec_count = '0;
      wr_idx = '0;
      run_min = 12'd3600;
      run_max = '0;
      mv_sum = '0;
      row_sum = '0;
    end else begin
      wr_idx = wr_idx + 8'd1;
    end
    return 1'b1;
  endfunction

  function automatic string fmt_result(input res_t r);
    return $sformatf("idx=%0d mv=%0d row=%0d done=%0d min=%0d max=%0d avg=%0d p2p=%0d ravg=%0d",
                     r.sample_index, r.millivolts, r.screen_row, r.record_done, r.volt_min,
                     r.volt_max, r.volt_avg, r.volt_peak_to_peak, r.row_avg);
  endfunction

  function automatic logic [11:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return trig_lvl;
    if (pick == 2) return 12'd0;
    if (pick == 3) return 12'd4095;
    return 12'($urandom);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_r && in_bus.ready) begin
        if (predict_kept_sample(in_sample_r, pred_res)) kept_sample_q.push_back(pred_res);
        samples_taken++;
        send_gap = steady ? 0 : $urandom_range(0, 16);
      end
      if (!in_valid_r || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_r <= 1'b0;
        end else if (adc_pending_q.size() > 0) begin
          in_sample_r <= adc_pending_q.pop_front();
          in_valid_r <= 1'b1;
        end else begin
          in_valid_r <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready_r <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_bus.valid && out_ready_r) begin
        got_res = {out_bus.sample_index, out_bus.millivolts, out_bus.screen_row,
                   out_bus.record_done, out_bus.volt_min, out_bus.volt_max, out_bus.volt_avg,
                   out_bus.volt_peak_to_peak, out_bus.row_avg};
        if (kept_sample_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction: %s", fmt_result(got_res));
        end else begin
          want_res = kept_sample_q.pop_front();
          if (got_res.sample_index !== want_res.sample_index ||
              got_res.millivolts !== want_res.millivolts ||
              got_res.screen_row !== want_res.screen_row ||
              got_res.record_done !== want_res.record_done ||
              got_res.volt_min !== want_res.volt_min ||
              got_res.volt_max !== want_res.volt_max ||
              got_res.volt_avg !== want_res.volt_avg ||
              got_res.volt_peak_to_peak !== want_res.volt_peak_to_peak ||
              got_res.row_avg !== want_res.row_avg) begin
            errors++;
            if (errors <= 10) begin
              $display("transaction %0d expected: %s", results_seen, fmt_result(want_res));
              $display("transaction %0d actual:   %s", results_seen, fmt_result(got_res));
            end
          end
        end
        results_seen++;
        recv_gap = steady ? 0 : $urandom_range(0, 16);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_r <= 1'b0;
      end else begin
        out_ready_r <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scope_capture_measure: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (samples_taken != samples_queued || kept_sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [11:0] x);
    adc_pending_q.push_back(x);
    samples_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TIMEBASE: tb_mode = val[1:0];
      CFG_TRIG_EN: trig_on = val[0];
      CFG_TRIG_LEVEL: trig_lvl = val[11:0];
      CFG_HOLD: hold_on = val[0];
      default: ;
    endcase
  endtask

  initial begin
    int n;
    int pick;
    logic [1:0] mode;
    logic [11:0] level;
    bit hold_pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // trigger at the top of the range, first record starts on the match
    write_reg(CFG_TRIG_EN, 12'd1);
    write_reg(CFG_TRIG_LEVEL, 12'd4095);
    queue_sample(12'd0);
    queue_sample(12'd2048);
    queue_sample(12'd4094);
    queue_sample(12'd4095);
    queue_sample(12'd0);
    queue_sample(12'd1);
    queue_sample(12'd2047);

    // held samples are dropped
    write_reg(CFG_HOLD, 12'd1);
    queue_sample(12'd4095);
    queue_sample(12'd0);
    write_reg(CFG_HOLD, 12'd0);

    // unused timebase code acts as every sample
    write_reg(CFG_TIMEBASE, {10'd0, TB_UNUSED});
    queue_sample(12'd4095);
    queue_sample(12'd17);

    // count past ten, then drop to tenth mid-record
    write_reg(CFG_TIMEBASE, {10'd0, TB_HUNDREDTH});
    for (int i = 0; i < 12; i++) queue_sample(12'($urandom));
    write_reg(CFG_TIMEBASE, {10'd0, TB_TENTH});
    queue_sample(12'd100);
    queue_sample(12'd3000);
    queue_sample(12'd4095);

    while (random_items < 2000) begin
      pick = $urandom_range(0, 7);
      mode = (pick < 5) ? TB_EVERY : (pick == 5) ? TB_TENTH :
             (pick == 6) ? TB_HUNDREDTH : TB_UNUSED;
      pick = $urandom_range(0, 5);
      level = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom);
      hold_pick = ($urandom_range(0, 7) == 0);
      steady = ($urandom_range(0, 3) == 0);
      write_reg(CFG_TIMEBASE, {10'($urandom), mode});
      write_reg(CFG_TRIG_EN, {11'($urandom), 1'($urandom)});
      write_reg(CFG_TRIG_LEVEL, level);
      write_reg(CFG_HOLD, {11'($urandom), hold_pick});
      if (hold_pick) n = $urandom_range(3, 12);
      else if (mode == TB_EVERY || mode == TB_UNUSED) n = $urandom_range(20, 300);
      else n = $urandom_range(50, 400);
      for (int i = 0; i < n; i++) queue_sample(draw_sample());
      if (!hold_pick) random_items += n;
    end

    wait_drained();
    if (errors == 0 && kept_sample_q.size() == 0) begin
      $display("scope_capture_measure: match");
    end else begin
      $display("scope_capture_measure: mismatch");
    end
    $finish;
  end

endmodule
